@@ src/tsk_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tsk_pkg: shared types and constants of the tetrahedral stiffness kernel
// Widths of the geometry and numerator datapath, pipeline control words and
// the corner-pair decode tables.
// ----------------------------------------------------------------------------
package tsk_pkg;

  localparam int COORD_W   = 16;
  localparam int NCOORD    = 12;
  localparam int DIFF_W    = 17;
  localparam int XP_W      = 34;
  localparam int SV_W      = 35;
  localparam int VP_W      = 52;
  localparam int VOL_W     = 54;
  localparam int DEN_W     = 57;
  localparam int DV_W      = 58;
  localparam int PP_W      = 70;
  localparam int PLO_W     = 35;
  localparam int DOT_W     = 72;
  localparam int QQ_W      = 73;
  localparam int QLO_W     = 36;
  localparam int COEF_W    = 31;
  localparam int LL_W      = COEF_W + 1 + PLO_W;
  localparam int MQ_W      = COEF_W + 1 + (QQ_W - QLO_W);
  localparam int NUM_W     = 102;
  localparam int NMAG_W    = 101;
  localparam int OUT_W     = 48;
  localparam int OUT_FRAC  = 16;
  localparam int QB        = OUT_W + 1;
  localparam int NENT      = 9;
  localparam int PAIR_W    = 4;
  localparam int NPAIRS    = 10;
  localparam int TUSER_W   = PAIR_W + 1;
  localparam int TU_DEG    = PAIR_W;
  localparam int IN_DATA_W = NCOORD * COORD_W;
  localparam int OUT_DATA_W = NENT * OUT_W;

  localparam int DEF_COORD_FRAC_BITS = 8;

  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;
  localparam logic CFG_IDX_LAMBDA = 1'b0;
  localparam logic CFG_IDX_MU     = 1'b1;
  localparam logic [COEF_W-1:0] LAMBDA_RST = 31'd280000;
  localparam logic [COEF_W-1:0] MU_RST     = 31'd31000;

  typedef logic [PAIR_W-1:0] pair_t;

  typedef struct packed {
    logic  valid;
    pair_t pair;
    logic  degen;
  } tsk_ctl_t;

  typedef struct packed {
    logic                              valid;
    pair_t                             pair;
    logic [NCOORD-1:0][COORD_W-1:0]    coord;
  } tsk_beat_t;

  typedef struct packed {
    tsk_ctl_t                       ctl;
    logic [DEN_W-1:0]               den;
    logic [NENT-1:0][PP_W-1:0]      pp;
    logic [NENT-1:0][QQ_W-1:0]      qq;
  } tsk_geom_t;

  typedef struct packed {
    tsk_ctl_t                       ctl;
    logic [NENT-1:0][OUT_W-1:0]     t;
  } tsk_res_t;

  // first corner of a pair
  function automatic logic [1:0] pair_row(input pair_t p);
    logic [1:0] r;
    unique case (p) inside
      [4'd0:4'd3]: r = 2'd0;
      [4'd4:4'd6]: r = 2'd1;
      [4'd7:4'd8]: r = 2'd2;
      default:     r = 2'd3;
    endcase
    return r;
  endfunction

  // second corner of a pair
  function automatic logic [1:0] pair_col(input pair_t p);
    logic [1:0] c;
    unique case (p) inside
      4'd0:             c = 2'd0;
      4'd1, 4'd4:       c = 2'd1;
      4'd2, 4'd5, 4'd7: c = 2'd2;
      default:          c = 2'd3;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

@@ src/tsk_seq.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tsk_seq: input word holding and corner-pair sequencer
// Takes one tetrahedron and issues ten beats, one per corner pair.
// ----------------------------------------------------------------------------
module tsk_seq (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        adv,
  input  wire logic                        s_tvalid,
  output logic                             s_tready,
  input  wire logic [tsk_pkg::IN_DATA_W-1:0] s_tdata,
  output tsk_pkg::tsk_beat_t               beat
);
  import tsk_pkg::*;

  logic                           busy;
  pair_t                          nxt;
  logic [NCOORD-1:0][COORD_W-1:0] hold;
  logic                           take;
  logic                           beat_valid;
  pair_t                          beat_pair;
  logic [NCOORD-1:0][COORD_W-1:0] beat_coord;

  assign s_tready = adv && !busy;
  assign take     = s_tvalid && s_tready;
  assign beat     = '{valid: beat_valid, pair: beat_pair, coord: beat_coord};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      nxt        <= '0;
      beat_valid <= 1'b0;
    end else if (adv) begin
      if (take) begin
        busy       <= 1'b1;
        nxt        <= PAIR_W'(1);
        beat_valid <= 1'b1;
      end else if (busy) begin
        beat_valid <= 1'b1;
        nxt        <= nxt + PAIR_W'(1);
        if (nxt == PAIR_W'(NPAIRS - 1)) begin
          busy <= 1'b0;
        end
      end else begin
        beat_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (take) begin
        hold       <= s_tdata;
        beat_coord <= s_tdata;
        beat_pair  <= '0;
      end else begin
        beat_coord <= hold;
        beat_pair  <= nxt;
      end
    end
  end

`ifndef SYNTHESIS
  a_first_pair: assert property (@(posedge clk) disable iff (rst)
    take |=> beat.valid && beat.pair == '0)
    else $error("accepted word did not start at pair zero");
  a_pair_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> nxt != '0 && nxt < PAIR_W'(NPAIRS))
    else $error("pair counter out of range");
  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    take |=> !take)
    else $error("second word taken while pairs still pending");
`endif

endmodule
`default_nettype wire

@@ src/tsk_geom.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tsk_geom: edge differences, shape vectors, volume and pair products
// Six stages: differences, cross terms, cross sums and pair select,
// products, sums, denominator and transposed terms.
// ----------------------------------------------------------------------------
module tsk_geom (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           adv,
  input  tsk_pkg::tsk_beat_t  beat,
  output tsk_pkg::tsk_geom_t  geo
);
  import tsk_pkg::*;

  localparam int AB = 0;
  localparam int AC = 1;
  localparam int AD = 2;
  localparam int BC = 3;
  localparam int BD = 4;
  localparam int CB = 5;
  localparam int CA = 6;
  localparam int XU [5] = '{AB, BC, AD, AB, CB};
  localparam int XV [5] = '{AC, BD, AC, AD, CA};
  localparam int PA [6] = '{1, 2, 2, 0, 0, 1};
  localparam int PB [6] = '{2, 1, 0, 2, 1, 0};

  tsk_ctl_t ctl [1:6];

  logic signed [COORD_W-1:0] pt    [4][3];
  logic signed [DIFF_W-1:0]  dif_n [7][3];
  logic signed [DIFF_W-1:0]  dif   [7][3];
  logic signed [XP_W-1:0]    xp_n  [5][6];
  logic signed [XP_W-1:0]    xp    [5][6];
  logic signed [DIFF_W-1:0]  ad2   [3];
  logic signed [SV_W-1:0]    w     [5][3];
  logic [2:0]                ri;
  logic [2:0]                ci;
  logic signed [SV_W-1:0]    n0    [3];
  logic signed [SV_W-1:0]    si    [3];
  logic signed [SV_W-1:0]    sj    [3];
  logic signed [DIFF_W-1:0]  ad3   [3];
  logic signed [VP_W-1:0]    vp    [3];
  logic signed [PP_W-1:0]    pp4   [NENT];
  logic signed [VOL_W-1:0]   vol;
  logic signed [DOT_W-1:0]   dot;
  logic signed [PP_W-1:0]    pp5   [NENT];
  logic [DEN_W-1:0]          den;
  logic [NENT-1:0][PP_W-1:0] pp6;
  logic [NENT-1:0][QQ_W-1:0] qq6;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      for (int k = 0; k < 3; k++) begin
        pt[i][k] = $signed(beat.coord[i*3+k]);
      end
    end
    for (int k = 0; k < 3; k++) begin
      dif_n[AB][k] = DIFF_W'(pt[1][k]) - DIFF_W'(pt[0][k]);
      dif_n[AC][k] = DIFF_W'(pt[2][k]) - DIFF_W'(pt[0][k]);
      dif_n[AD][k] = DIFF_W'(pt[3][k]) - DIFF_W'(pt[0][k]);
      dif_n[BC][k] = DIFF_W'(pt[2][k]) - DIFF_W'(pt[1][k]);
      dif_n[BD][k] = DIFF_W'(pt[3][k]) - DIFF_W'(pt[1][k]);
      dif_n[CB][k] = DIFF_W'(pt[1][k]) - DIFF_W'(pt[2][k]);
      dif_n[CA][k] = DIFF_W'(pt[0][k]) - DIFF_W'(pt[2][k]);
    end
  end

  // cross terms: vectors n0, s0, s1, s2, s3 in that order
  always_comb begin
    for (int c = 0; c < 5; c++) begin
      for (int t = 0; t < 6; t++) begin
        xp_n[c][t] = XP_W'(dif[XU[c]][PA[t]]) * XP_W'(dif[XV[c]][PB[t]]);
      end
    end
  end

  always_comb begin
    for (int c = 0; c < 5; c++) begin
      for (int m = 0; m < 3; m++) begin
        w[c][m] = SV_W'(xp[c][2*m]) - SV_W'(xp[c][2*m+1]);
      end
    end
    ri = 3'(pair_row(ctl[2].pair)) + 3'd1;
    ci = 3'(pair_col(ctl[2].pair)) + 3'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 1; s <= 6; s++) begin
        ctl[s] <= '0;
      end
    end else if (adv) begin
      ctl[1] <= '{valid: beat.valid, pair: beat.pair, degen: 1'b0};
      for (int s = 2; s <= 5; s++) begin
        ctl[s] <= ctl[s-1];
      end
      ctl[6] <= '{valid: ctl[5].valid, pair: ctl[5].pair, degen: (vol == '0)};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dif <= dif_n;
      xp  <= xp_n;
      for (int k = 0; k < 3; k++) begin
        ad2[k] <= dif[AD][k];
        ad3[k] <= ad2[k];
        n0[k]  <= w[0][k];
        si[k]  <= w[ri][k];
        sj[k]  <= w[ci][k];
        vp[k]  <= VP_W'(n0[k]) * VP_W'(ad3[k]);
      end
      for (int k = 0; k < 3; k++) begin
        for (int l = 0; l < 3; l++) begin
          pp4[k*3+l] <= PP_W'(si[k]) * PP_W'(sj[l]);
        end
      end
      vol <= VOL_W'(vp[0]) + VOL_W'(vp[1]) + VOL_W'(vp[2]);
      dot <= DOT_W'(pp4[0]) + DOT_W'(pp4[4]) + DOT_W'(pp4[8]);
      pp5 <= pp4;
      den <= (DEN_W'(vol) <<< 2) + (DEN_W'(vol) <<< 1);
      for (int k = 0; k < 3; k++) begin
        for (int l = 0; l < 3; l++) begin
          pp6[k*3+l] <= pp5[k*3+l];
          qq6[k*3+l] <= QQ_W'(pp5[l*3+k]) + ((k == l) ? QQ_W'(dot) : QQ_W'(0));
        end
      end
    end
  end

  assign geo = '{ctl: ctl[6], den: den, pp: pp6, qq: qq6};

endmodule
`default_nettype wire

@@ src/tsk_numer.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tsk_numer: numerator assembly for the nine tensor entries
// Splits the coefficient products into partial products, sums them, takes
// the magnitude and forms the rounded dividend and doubled divisor.
// ----------------------------------------------------------------------------
module tsk_numer #(
  parameter int COORD_FRAC_BITS = tsk_pkg::DEF_COORD_FRAC_BITS,
  parameter int NV_W = tsk_pkg::NMAG_W + tsk_pkg::OUT_FRAC - COORD_FRAC_BITS + 2
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          adv,
  input  wire logic [tsk_pkg::COEF_W-1:0]    lame_lambda,
  input  wire logic [tsk_pkg::COEF_W-1:0]    lame_mu,
  input  tsk_pkg::tsk_geom_t                 geo,
  output tsk_pkg::tsk_ctl_t                  ctl_o,
  output logic [tsk_pkg::NENT-1:0]           neg_o,
  output logic [tsk_pkg::DV_W-1:0]           dv_o,
  output logic [tsk_pkg::NENT-1:0][NV_W-1:0] nval_o
);
  import tsk_pkg::*;

  localparam int SHIFT = OUT_FRAC - COORD_FRAC_BITS;

  tsk_ctl_t ctl [1:5];

  logic [COEF_W:0]          lam_u;
  logic [COEF_W:0]          mu_u;
  logic [LL_W-1:0]          ll   [NENT];
  logic signed [LL_W-1:0]   lh   [NENT];
  logic [MQ_W-1:0]          ml   [NENT];
  logic signed [MQ_W-1:0]   mh   [NENT];
  logic [DEN_W-1:0]         dm1, dm2, dm3, dm4;
  logic                     dneg1, dneg2, dneg3;
  logic signed [NUM_W-1:0]  lp   [NENT];
  logic signed [NUM_W-1:0]  mq   [NENT];
  logic signed [NUM_W-1:0]  num  [NENT];
  logic [NMAG_W-1:0]        nmag [NENT];
  logic [NENT-1:0]          neg4;

  assign lam_u = {1'b0, lame_lambda};
  assign mu_u  = {1'b0, lame_mu};

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 1; s <= 5; s++) begin
        ctl[s] <= '0;
      end
    end else if (adv) begin
      ctl[1] <= geo.ctl;
      for (int s = 2; s <= 5; s++) begin
        ctl[s] <= ctl[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int e = 0; e < NENT; e++) begin
        ll[e] <= LL_W'(lam_u) * LL_W'(geo.pp[e][PLO_W-1:0]);
        lh[e] <= LL_W'($signed(lam_u)) * LL_W'($signed(geo.pp[e][PP_W-1:PLO_W]));
        ml[e] <= MQ_W'(mu_u) * MQ_W'(geo.qq[e][QLO_W-1:0]);
        mh[e] <= MQ_W'($signed(mu_u)) * MQ_W'($signed(geo.qq[e][QQ_W-1:QLO_W]));
        lp[e] <= (NUM_W'(lh[e]) <<< PLO_W) + $signed(NUM_W'(ll[e]));
        mq[e] <= (NUM_W'(mh[e]) <<< QLO_W) + $signed(NUM_W'(ml[e]));
        num[e] <= lp[e] + mq[e];
        nmag[e] <= num[e][NUM_W-1] ? NMAG_W'(-num[e]) : NMAG_W'(num[e]);
        neg4[e] <= num[e][NUM_W-1] ^ dneg3;
        // shift to output scale, double, add half the divisor for rounding
        nval_o[e] <= (NV_W'(nmag[e]) << (SHIFT + 1)) + NV_W'(dm4);
      end
      dneg1 <= geo.den[DEN_W-1];
      dm1   <= geo.den[DEN_W-1] ? DEN_W'(-$signed(geo.den)) : geo.den;
      dneg2 <= dneg1;
      dneg3 <= dneg2;
      dm2   <= dm1;
      dm3   <= dm2;
      dm4   <= dm3;
      neg_o <= neg4;
      dv_o  <= DV_W'(dm4) << 1;
    end
  end

  assign ctl_o = ctl[5];

endmodule
`default_nettype wire

@@ src/tsk_div.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tsk_div: pipelined restoring divider, nine lanes, one quotient bit a stage
// An overflow check up front covers quotients too wide for QB bits; the
// last stage saturates, applies the sign and zeroes degenerate elements.
// ----------------------------------------------------------------------------
module tsk_div #(
  parameter int NV_W = 111
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          adv,
  input  tsk_pkg::tsk_ctl_t                  ctl_i,
  input  wire logic [tsk_pkg::NENT-1:0]      neg_i,
  input  wire logic [tsk_pkg::DV_W-1:0]      dv_i,
  input  wire logic [tsk_pkg::NENT-1:0][NV_W-1:0] nval_i,
  output tsk_pkg::tsk_res_t                  res
);
  import tsk_pkg::*;

  localparam int HI_W  = NV_W - QB;
  localparam int CMP_W = (HI_W > DV_W) ? HI_W : DV_W;

  tsk_ctl_t         ctl  [QB+1];
  logic [NENT-1:0]  negv [QB+1];
  logic [NENT-1:0]  ovf  [QB+1];
  logic [DV_W-1:0]  dv   [QB+1];
  logic [DV_W-1:0]  rem  [QB+1][NENT];
  logic [QB-1:0]    low  [QB+1][NENT];
  logic [QB-1:0]    q    [QB+1][NENT];
  logic [OUT_W-1:0] tn   [NENT];
  tsk_ctl_t                   res_ctl;
  logic [NENT-1:0][OUT_W-1:0] res_t;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl[0] <= '0;
    end else if (adv) begin
      ctl[0] <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      negv[0] <= neg_i;
      dv[0]   <= dv_i;
      for (int e = 0; e < NENT; e++) begin
        ovf[0][e] <= CMP_W'(nval_i[e][NV_W-1:QB]) >= CMP_W'(dv_i);
        rem[0][e] <= DV_W'(nval_i[e][NV_W-1:QB]);
        low[0][e] <= nval_i[e][QB-1:0];
        q[0][e]   <= '0;
      end
    end
  end

  for (genvar s = 0; s < QB; s++) begin : g_bit
    logic [DV_W:0] t  [NENT];
    logic          ge [NENT];

    always_comb begin
      for (int e = 0; e < NENT; e++) begin
        t[e]  = {rem[s][e], low[s][e][QB-1]};
        ge[e] = t[e] >= {1'b0, dv[s]};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        ctl[s+1] <= '0;
      end else if (adv) begin
        ctl[s+1] <= ctl[s];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        negv[s+1] <= negv[s];
        ovf[s+1]  <= ovf[s];
        dv[s+1]   <= dv[s];
        for (int e = 0; e < NENT; e++) begin
          rem[s+1][e] <= ge[e] ? DV_W'(t[e] - {1'b0, dv[s]}) : DV_W'(t[e]);
          low[s+1][e] <= low[s][e] << 1;
          q[s+1][e]   <= {q[s][e][QB-2:0], ge[e]};
        end
      end
    end
  end

  // saturate to the signed output range, then apply the sign
  always_comb begin
    logic [QB-1:0]    lim;
    logic [OUT_W-1:0] qm;
    for (int e = 0; e < NENT; e++) begin
      lim = negv[QB][e] ? (QB'(1) << (OUT_W - 1)) : ((QB'(1) << (OUT_W - 1)) - QB'(1));
      qm  = (ovf[QB][e] || q[QB][e] > lim) ? OUT_W'(lim) : OUT_W'(q[QB][e]);
      if (ctl[QB].degen) begin
        tn[e] = '0;
      end else begin
        tn[e] = negv[QB][e] ? -qm : qm;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_ctl <= '0;
    end else if (adv) begin
      res_ctl <= ctl[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int e = 0; e < NENT; e++) begin
        res_t[e] <= tn[e];
      end
    end
  end

  assign res = '{ctl: res_ctl, t: res_t};

endmodule
`default_nettype wire

@@ src/tsk_obuf.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tsk_obuf: two-word output buffer
// Decouples the pipeline from the receiver; the pipeline advances while a
// slot is free.
// ----------------------------------------------------------------------------
module tsk_obuf (
  input  wire logic          clk,
  input  wire logic          rst,
  input  tsk_pkg::tsk_res_t  res,
  output logic               adv,
  output logic               m_tvalid,
  input  wire logic          m_tready,
  output tsk_pkg::tsk_res_t  head
);
  import tsk_pkg::*;

  tsk_res_t   slot [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;
  logic       push;
  logic       pop;

  assign adv      = cnt != 2'd2;
  assign push     = adv && res.ctl.valid;
  assign m_tvalid = cnt != 2'd0;
  assign pop      = m_tvalid && m_tready;
  assign head     = slot[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wp] <= res;
    end
  end

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt != 2'd3)
    else $error("output buffer count out of range");
  a_full_hold: assert property (@(posedge clk) disable iff (rst)
    cnt == 2'd2 && !pop |=> cnt == 2'd2)
    else $error("full buffer lost a word");
  a_push_count: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> cnt == $past(cnt) + 2'd1)
    else $error("pushed word not counted");
`endif

endmodule
`default_nettype wire

@@ src/tet_stiffness_tensor_kernel.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tet_stiffness_tensor_kernel: element stiffness tensors of one tetrahedron
// Input stream: one word holds the four corner coordinates (Q8.8). Output
// stream: ten words per tetrahedron, one per corner pair, each a 3x3 tensor
// in Q32.16 divided by 36 times the rest volume, saturated to 48 bits.
// tuser carries the pair index and the degenerate flag, tlast marks pair 9.
// Throughput: one output word per cycle while the receiver is ready; the pair
// sequencer issues one pair per cycle while the pipeline advances and takes a
// new tetrahedron once all pairs of the last are issued. Most of the path from
// an input word to its first output word lies in the 49-stage divider. Reset
// clears the pipeline and the output buffer and loads the Lame
// registers with their defaults. A two-word output buffer keeps the pipeline
// running while the receiver holds one word; with both slots full the whole
// pipeline holds and s_tready falls. Lame registers sit on the APB port at
// byte addresses 0 and 4; write them only while the block is idle.
// ----------------------------------------------------------------------------
module tet_stiffness_tensor_kernel #(
  parameter int COORD_FRAC_BITS = tsk_pkg::DEF_COORD_FRAC_BITS
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  // ax, ay, az, bx, by_coord, bz, cx, cy, cz, dx, dy, dz
  input  wire logic [tsk_pkg::IN_DATA_W-1:0]    s_tdata,
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  // t00, t01, t02, t10, t11, t12, t20, t21, t22
  output logic [tsk_pkg::OUT_DATA_W-1:0]        m_tdata,
  output logic                                  m_tlast,
  // pair_index, degenerate
  output logic [tsk_pkg::TUSER_W-1:0]           m_tuser,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [tsk_pkg::CFG_ADDR_W-1:0]   paddr,
  input  wire logic [tsk_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [tsk_pkg::CFG_DATA_W-1:0]        prdata,
  output logic                                  pready
);
  import tsk_pkg::*;

  localparam int NV_W = NMAG_W + OUT_FRAC - COORD_FRAC_BITS + 2;

  logic [COEF_W-1:0]          lame_lambda;
  logic [COEF_W-1:0]          lame_mu;
  logic                       adv;
  tsk_beat_t                  beat;
  tsk_geom_t                  geo;
  tsk_ctl_t                   nctl;
  logic [NENT-1:0]            nneg;
  logic [DV_W-1:0]            ndv;
  logic [NENT-1:0][NV_W-1:0]  nval;
  tsk_res_t                   res;
  tsk_res_t                   head;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      lame_lambda <= LAMBDA_RST;
      lame_mu     <= MU_RST;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[2])
        CFG_IDX_LAMBDA: lame_lambda <= pwdata[COEF_W-1:0];
        CFG_IDX_MU:     lame_mu     <= pwdata[COEF_W-1:0];
        default:        ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      CFG_IDX_LAMBDA: prdata = {1'b0, lame_lambda};
      CFG_IDX_MU:     prdata = {1'b0, lame_mu};
      default:        prdata = '0;
    endcase
  end

  tsk_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .beat     (beat)
  );

  tsk_geom u_geom (
    .clk  (clk),
    .rst  (rst),
    .adv  (adv),
    .beat (beat),
    .geo  (geo)
  );

  tsk_numer #(
    .COORD_FRAC_BITS (COORD_FRAC_BITS),
    .NV_W            (NV_W)
  ) u_numer (
    .clk         (clk),
    .rst         (rst),
    .adv         (adv),
    .lame_lambda (lame_lambda),
    .lame_mu     (lame_mu),
    .geo         (geo),
    .ctl_o       (nctl),
    .neg_o       (nneg),
    .dv_o        (ndv),
    .nval_o      (nval)
  );

  tsk_div #(
    .NV_W (NV_W)
  ) u_div (
    .clk    (clk),
    .rst    (rst),
    .adv    (adv),
    .ctl_i  (nctl),
    .neg_i  (nneg),
    .dv_i   (ndv),
    .nval_i (nval),
    .res    (res)
  );

  tsk_obuf u_obuf (
    .clk      (clk),
    .rst      (rst),
    .res      (res),
    .adv      (adv),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .head     (head)
  );

  assign m_tdata = head.t;
  assign m_tuser = {head.ctl.degen, head.ctl.pair};
  assign m_tlast = head.ctl.pair == PAIR_W'(NPAIRS - 1);

`ifndef SYNTHESIS
  a_last_pair: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tuser[PAIR_W-1:0] == PAIR_W'(NPAIRS - 1))
    else $error("tlast on a pair other than the tenth");
  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[TU_DEG] |-> m_tdata == '0)
    else $error("degenerate element with nonzero tensor");
  a_item_gap: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken on consecutive cycles");
`endif

endmodule
`default_nettype wire

@@ test/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench of the tetrahedral stiffness tensor kernel
// Streams tetrahedra into the kernel under several Lame settings and checks
// every tensor word against an exact wide-integer computation of the ten
// pair tensors. Covers flat, inverted, saturating and random shapes, with
// random idling on both streams.
// ----------------------------------------------------------------------------
module tb;
  import tsk_pkg::*;

  typedef logic signed [127:0] s128_t;
  typedef struct packed {
    logic [OUT_DATA_W-1:0] tens;
    logic [TUSER_W-1:0]    user;
    logic                  last;
  } tensor_word_t;

  localparam int SHIFT = 16 - DEF_COORD_FRAC_BITS;
  localparam int DRAIN_CYCLES = 80;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_DATA_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic m_tlast;
  logic [TUSER_W-1:0] m_tuser;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic pready;

  tet_stiffness_tensor_kernel uut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  logic [COEF_W-1:0] lambda_q = LAMBDA_RST;
  logic [COEF_W-1:0] mu_q = MU_RST;
  tensor_word_t tensor_q[$];
  int mismatches = 0;
  bit calm = 1'b0;

  function automatic void cross3(input longint u[3], input longint v[3],
                                 output longint w[3]);
    w[0] = u[1] * v[2] - u[2] * v[1];
    w[1] = u[2] * v[0] - u[0] * v[2];
    w[2] = u[0] * v[1] - u[1] * v[0];
  endfunction

  // exact tensor entry: round(num/den), ties away from zero, saturated
  function automatic logic [OUT_W-1:0] round_sat(input s128_t num, input longint den);
    logic [127:0] nm, dm, q, lim;
    logic neg;
    neg = (num < 0) != (den < 0);
    nm = num < 0 ? -num : num;
    dm = den < 0 ? -s128_t'(den) : s128_t'(den);
    q = (2 * nm + dm) / (2 * dm);
    lim = neg ? (128'd1 << (OUT_W - 1)) : (128'd1 << (OUT_W - 1)) - 1;
    if (q > lim) q = lim;
    return neg ? OUT_W'(-q) : OUT_W'(q);
  endfunction

  function automatic void predict_tensors(input logic [IN_DATA_W-1:0] w);
    longint p[4][3];
    longint ab[3], ac[3], ad[3], bc[3], bd[3], cb[3], ca[3], n0[3];
    longint s[4][3];
    longint vol6;
    s128_t dot, num, lam, mu;
    tensor_word_t tw;
    int pair;
    pair = 0;
    lam = s128_t'({1'b0, lambda_q});
    mu = s128_t'({1'b0, mu_q});
    for (int i = 0; i < 4; i++)
      for (int k = 0; k < 3; k++)
        p[i][k] = longint'($signed(w[(i * 3 + k) * COORD_W +: COORD_W]));
    for (int k = 0; k < 3; k++) begin
      ab[k] = p[1][k] - p[0][k];
      ac[k] = p[2][k] - p[0][k];
      ad[k] = p[3][k] - p[0][k];
      bc[k] = p[2][k] - p[1][k];
      bd[k] = p[3][k] - p[1][k];
      cb[k] = -bc[k];
      ca[k] = -ac[k];
    end
    cross3(ab, ac, n0);
    vol6 = n0[0] * ad[0] + n0[1] * ad[1] + n0[2] * ad[2];
    cross3(bc, bd, s[0]);
    cross3(ad, ac, s[1]);
    cross3(ab, ad, s[2]);
    cross3(cb, ca, s[3]);
    for (int i = 0; i < 4; i++)
      for (int j = i; j < 4; j++) begin
        dot = '0;
        for (int m = 0; m < 3; m++)
          dot += s128_t'(s[i][m]) * s128_t'(s[j][m]);
        for (int k = 0; k < 3; k++)
          for (int l = 0; l < 3; l++) begin
            if (vol6 == 0) begin
              tw.tens[(k * 3 + l) * OUT_W +: OUT_W] = '0;
            end else begin
              num = lam * s128_t'(s[i][k]) * s128_t'(s[j][l])
                  + mu * s128_t'(s[i][l]) * s128_t'(s[j][k]);
              if (k == l) num += mu * dot;
              num = num <<< SHIFT;
              tw.tens[(k * 3 + l) * OUT_W +: OUT_W] = round_sat(num, vol6 * 6);
            end
          end
        tw.user = {vol6 == 0, PAIR_W'(pair)};
        tw.last = pair == NPAIRS - 1;
        tensor_q = {tensor_q, tw};
        pair++;
      end
  endfunction

  // receiver: random stall bursts unless calm
  int stall_left = 0;
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 4) == 0) begin
      m_tready <= 1'b0;
      stall_left <= $urandom_range(0, 2);
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    tensor_word_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (tensor_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word user=%h", m_tuser);
      end else begin
        want = tensor_q.pop_front();
        for (int e = 0; e < NENT; e++)
          if (m_tdata[e * OUT_W +: OUT_W] !== want.tens[e * OUT_W +: OUT_W]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("pair %0d entry %0d: exp %h got %h", want.user[PAIR_W-1:0], e,
                       want.tens[e * OUT_W +: OUT_W], m_tdata[e * OUT_W +: OUT_W]);
          end
        if (m_tuser !== want.user || m_tlast !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("tuser/tlast: exp %h/%b got %h/%b", want.user, want.last,
                     m_tuser, m_tlast);
        end
      end
    end
  end

  task automatic send_tet(input logic [IN_DATA_W-1:0] w);
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_tvalid = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    s_tdata = w;
    s_tvalid = 1'b1;
    do @(posedge clk); while (!s_tready);
    predict_tensors(w);
    @(negedge clk);
  endtask

  function automatic logic [IN_DATA_W-1:0] pack_tet(input shortint c[12]);
    logic [IN_DATA_W-1:0] w;
    for (int i = 0; i < NCOORD; i++) w[i * COORD_W +: COORD_W] = c[i];
    return w;
  endfunction

  task automatic drain;
    s_tvalid = 1'b0;
    while (tensor_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_write(input logic idx, input logic [CFG_DATA_W-1:0] value);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = {idx, 2'b00};
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == CFG_IDX_LAMBDA) lambda_q = value[COEF_W-1:0];
    else mu_q = value[COEF_W-1:0];
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic send_random(input int n, input int span);
    shortint c[12];
    for (int t = 0; t < n; t++) begin
      case ($urandom_range(0, 5))
        0: for (int i = 0; i < 12; i++) c[i] = shortint'($urandom());
        1: begin
          // flat: fourth corner on the plane of the other three
          for (int i = 0; i < 9; i++) c[i] = shortint'($urandom_range(0, 2 * span) - span);
          for (int k = 0; k < 3; k++) c[9 + k] = c[k] + c[3 + k] - c[6 + k];
        end
        default:
          for (int i = 0; i < 12; i++) c[i] = shortint'($urandom_range(0, 2 * span) - span);
      endcase
      send_tet(pack_tet(c));
    end
  endtask

  task automatic test_directed;
    shortint shapes[][12];
    shapes = '{
      '{0, 0, 0, 256, 0, 0, 0, 256, 0, 0, 0, 256},
      '{0, 0, 0, 0, 256, 0, 256, 0, 0, 0, 0, 256},          // inverted
      '{5, 5, 5, 5, 5, 5, 5, 5, 5, 5, 5, 5},                // all corners equal
      '{0, 0, 0, 256, 0, 0, 512, 0, 0, 768, 0, 0},          // collinear
      '{0, 0, 0, 256, 0, 0, 0, 256, 0, 256, 256, 0},        // coplanar
      '{-32768, -32768, -32768, 32767, -32768, -32768,
        -32768, 32767, -32768, -32768, -32768, 32767},
      '{32767, 32767, 32767, -32768, 32767, 32767,
        32767, -32768, 32767, 32767, 32767, -32768},
      '{0, 0, 0, 32767, 0, 0, 0, 32767, 0, 0, 0, 1},        // thin sliver
      '{0, 0, 0, -32768, 0, 0, 0, 32767, 0, 0, 0, -1},
      '{1, 0, 0, 0, 1, 0, 0, 0, 1, 0, 0, 0},
      '{-1, -1, -1, 0, 0, 0, -1, 0, 0, 0, -1, 0},
      '{100, -200, 300, -400, 500, -600, 700, -800, 900, -1000, 1100, 1200},
      '{-32768, 0, 32767, 0, -32768, 0, 32767, 0, -32768, -1, -1, -1}
    };
    foreach (shapes[i]) send_tet(pack_tet(shapes[i]));
  endtask

  task automatic test_zero_coefs;
    drain();
    cfg_write(CFG_IDX_LAMBDA, '0);
    cfg_write(CFG_IDX_MU, '0);
    send_random(10, 2000);
    drain();
    cfg_write(CFG_IDX_MU, 32'd1);
    send_random(10, 2000);
  endtask

  task automatic test_max_coefs;
    drain();
    cfg_write(CFG_IDX_LAMBDA, 32'hFFFF_FFFF);
    cfg_write(CFG_IDX_MU, 32'h7FFF_FFFF);
    test_directed();
    send_random(15, 32767);
  endtask

  task automatic test_random_coefs;
    for (int ph = 0; ph < 4; ph++) begin
      drain();
      cfg_write(CFG_IDX_LAMBDA, $urandom());
      cfg_write(CFG_IDX_MU, $urandom_range(0, 1 << (ph * 8)));
      send_random(32, ph == 0 ? 32767 : 4000);
    end
  endtask

  task automatic test_steady;
    drain();
    cfg_write(CFG_IDX_LAMBDA, 32'd280000);
    cfg_write(CFG_IDX_MU, 32'd31000);
    calm = 1'b1;
    send_random(50, 3000);
  endtask

  initial begin
    int waited;
    repeat (3) @(negedge clk);
    rst = 1'b0;
    test_directed();
    send_random(40, 1000);
    test_zero_coefs();
    test_max_coefs();
    test_random_coefs();
    test_steady();
    s_tvalid = 1'b0;
    waited = 0;
    while (tensor_q.size() != 0 && waited < 20000) begin
      @(negedge clk);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0 && tensor_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule
